/* rtl/lsoc_pkg.sv */
// shared types and constants of the line segment overlap counter
package lsoc_pkg;

   localparam int COORD_W = 10;
   localparam int TOTAL_W = 21;
   localparam int HITS_W  = 2;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
   localparam logic [HITS_W-1:0]  HITS_ONE  = 2'd1;
   localparam logic [HITS_W-1:0]  HITS_SAT  = 2'd2;

   // one grid cell produced by the segment walker
   typedef struct packed {
      logic               valid;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } cell_type;

   // status of the hit counter memory
   typedef struct packed {
      logic clearing;
      logic busy;
   } mem_status_type;

endpackage

/* rtl/lsoc_walker.sv */
// segment walker: classifies a segment and steps through its cells, one per cycle
module lsoc_walker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lsoc_pkg::COORD_W-1:0] x_start,
   input  logic [lsoc_pkg::COORD_W-1:0] y_start,
   input  logic [lsoc_pkg::COORD_W-1:0] x_end,
   input  logic [lsoc_pkg::COORD_W-1:0] y_end,
   output logic                         drawn,
   output lsoc_pkg::cell_type           grid_cell
);
   import lsoc_pkg::*;

   typedef enum logic [1:0] {STEP_NONE, STEP_INC, STEP_DEC} step_type;

   logic signed [COORD_W:0] dx;
   logic signed [COORD_W:0] dy;
   logic [COORD_W-1:0]      adx;
   logic [COORD_W-1:0]      ady;
   logic [COORD_W-1:0]      len;
   step_type                x_dir;
   step_type                y_dir;

   logic                    active_ff;
   logic [COORD_W-1:0]      x_ff;
   logic [COORD_W-1:0]      y_ff;
   logic [COORD_W-1:0]      len_ff;
   step_type                x_dir_ff;
   step_type                y_dir_ff;
   logic [COORD_W-1:0]      x_in;
   logic [COORD_W-1:0]      y_in;

   always_comb begin
      dx    = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
      dy    = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
      adx   = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
      ady   = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
      drawn = (adx == '0) || (ady == '0) || (adx == ady);
      len   = (adx > ady) ? adx : ady;
      priority if (x_end > x_start) x_dir = STEP_INC;
      else if (x_end < x_start)     x_dir = STEP_DEC;
      else                          x_dir = STEP_NONE;
      priority if (y_end > y_start) y_dir = STEP_INC;
      else if (y_end < y_start)     y_dir = STEP_DEC;
      else                          y_dir = STEP_NONE;
   end

   always_comb begin
      unique case (x_dir_ff)
         STEP_INC: x_in = x_ff + 1'b1;
         STEP_DEC: x_in = x_ff - 1'b1;
         default:  x_in = x_ff;
      endcase
      unique case (y_dir_ff)
         STEP_INC: y_in = y_ff + 1'b1;
         STEP_DEC: y_in = y_ff - 1'b1;
         default:  y_in = y_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (start) begin
         active_ff <= drawn;
      end else if (active_ff && len_ff == '0) begin
         active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff     <= x_start;
         y_ff     <= y_start;
         len_ff   <= len;
         x_dir_ff <= x_dir;
         y_dir_ff <= y_dir;
      end else if (active_ff) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         len_ff <= len_ff - 1'b1;
      end
   end

   assign grid_cell.valid = active_ff;
   assign grid_cell.x     = x_ff;
   assign grid_cell.y     = y_ff;

endmodule

/* rtl/lsoc_cell_mem.sv */
// hit counter memory with read-modify-write pipeline, clearing sweep and overlap total
module lsoc_cell_mem #(
   parameter int unsigned GRID_SIDE = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  lsoc_pkg::cell_type           grid_cell,
   output lsoc_pkg::mem_status_type     status,
   output logic [lsoc_pkg::TOTAL_W-1:0] total
);
   import lsoc_pkg::*;

   localparam int unsigned DEPTH = GRID_SIDE * GRID_SIDE;
   localparam int          AW    = $clog2(DEPTH);

   logic [HITS_W-1:0]  mem_ff [DEPTH];

   logic               in_grid;
   logic [AW-1:0]      addr;
   logic               pend_valid_ff;
   logic [AW-1:0]      pend_addr_ff;
   logic               wb_valid_ff;
   logic [AW-1:0]      wb_addr_ff;
   logic [HITS_W-1:0]  rd_data_ff;
   logic               clearing_ff;
   logic [AW-1:0]      clear_addr_ff;
   logic [TOTAL_W-1:0] total_ff;

   // cells past the grid edge are skipped
   assign in_grid = (32'(grid_cell.x) < GRID_SIDE) && (32'(grid_cell.y) < GRID_SIDE);
   assign addr    = AW'(32'(grid_cell.x) * GRID_SIDE + 32'(grid_cell.y));

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         wb_valid_ff   <= 1'b0;
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
         total_ff      <= '0;
      end else begin
         pend_valid_ff <= grid_cell.valid && in_grid;
         wb_valid_ff   <= pend_valid_ff;
         if (clearing_ff) begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
            if (clear_addr_ff == AW'(DEPTH - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         if (wb_valid_ff && rd_data_ff == HITS_ONE && total_ff != TOTAL_MAX) begin
            total_ff <= total_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= addr;
      wb_addr_ff   <= pend_addr_ff;
   end

   // cells of one segment are distinct and segments never overlap in the pipe,
   // so the read never meets the pending write of the same cell
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[pend_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         mem_ff[clear_addr_ff] <= '0;
      end else if (wb_valid_ff && rd_data_ff < HITS_SAT) begin
         mem_ff[wb_addr_ff] <= rd_data_ff + 1'b1;
      end
   end

   assign status.clearing = clearing_ff;
   assign status.busy     = pend_valid_ff | wb_valid_ff;
   assign total           = total_ff;

endmodule

/* rtl/line_segment_overlap_counter.sv */
// Line segment overlap counter: draws straight and 45-degree segments into a
// grid of saturating hit counters and counts the cells hit two or more times.
// Request channel (req_valid/req_ready) carries one segment per transaction as
// two endpoints; response channel (rsp_valid/rsp_ready) returns one transaction
// per segment with the running overlap total and a drawn flag.
// The walker feeds one cell per cycle into a read-modify-write pipeline on
// the grid memory, which reads one cell while it writes back another.
// One segment is in flight at a time; a new request is taken while the last
// response still waits in the output register.
// After reset the grid memory is cleared by a sweep over all
// GRID_SIDE * GRID_SIDE cells; req_ready stays low until it ends.
// When the receiver stalls, the finished result waits for the output register
// to free up and no further request is taken.
module line_segment_overlap_counter #(
   parameter int unsigned GRID_SIDE = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [lsoc_pkg::COORD_W-1:0] req_x_start,
   input  logic [lsoc_pkg::COORD_W-1:0] req_y_start,
   input  logic [lsoc_pkg::COORD_W-1:0] req_x_end,
   input  logic [lsoc_pkg::COORD_W-1:0] req_y_end,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lsoc_pkg::TOTAL_W-1:0] rsp_overlap_total,
   output logic                         rsp_segment_drawn
);
   import lsoc_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DONE} state_type;

   state_type          state_ff;
   logic               rsp_valid_ff;
   logic [TOTAL_W-1:0] rsp_overlap_total_ff;
   logic               rsp_segment_drawn_ff;
   logic               drawn_ff;

   logic               accept;
   logic               drawn;
   cell_type           grid_cell;
   mem_status_type     mem_status;
   logic [TOTAL_W-1:0] total;

   assign req_ready = (state_ff == ST_IDLE) && !mem_status.clearing;
   assign accept    = req_valid && req_ready;

   lsoc_walker u_walker (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .x_start   (req_x_start),
      .y_start   (req_y_start),
      .x_end     (req_x_end),
      .y_end     (req_y_end),
      .drawn     (drawn),
      .grid_cell (grid_cell)
   );

   lsoc_cell_mem #(
      .GRID_SIDE (GRID_SIDE)
   ) u_cell_mem (
      .clock     (clock),
      .reset     (reset),
      .grid_cell (grid_cell),
      .status    (mem_status),
      .total     (total)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  drawn_ff <= drawn;
                  state_ff <= ST_WALK;
               end
            end
            ST_WALK: begin
               // wait for the last write to land in the grid
               if (!grid_cell.valid && !mem_status.busy) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff         <= 1'b1;
                  rsp_overlap_total_ff <= total;
                  rsp_segment_drawn_ff <= drawn_ff;
                  state_ff             <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_overlap_total = rsp_overlap_total_ff;
   assign rsp_segment_drawn = rsp_segment_drawn_ff;

endmodule
